/* hw/rtl/acfp_pkg.sv */
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared constants, character codes and types of the ascii command frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

    // frame store and frame limits
    localparam int STORE_DEPTH = 32;
    localparam int FRAME_MAX   = 21;
    localparam int NUMBER_MAX  = 16;

    localparam int CNT_W = $clog2(STORE_DEPTH);

    // fixed byte positions inside a frame
    localparam int IDX_KIND   = 1;
    localparam int IDX_ACTION = 2;
    localparam int IDX_EQ     = 3;
    localparam int NUM_START  = 4;

    // fixed point format
    localparam int FRAC_BITS = 16;
    localparam int IP_W      = 17;
    localparam logic [IP_W-1:0] IP_SAT = {1'b1, {(IP_W-1){1'b0}}};
    localparam int IP10_W    = IP_W + 4;
    localparam int MAG_W     = IP_W + FRAC_BITS;

    function automatic longint unsigned pow10(input int n);
        longint unsigned p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // longest fraction that still fits a number field
    localparam int FRAC_DIGITS = NUMBER_MAX - 2;
    localparam int FD_W        = $clog2(pow10(FRAC_DIGITS) + 64'd1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VTAB  = 8'h0B;
    localparam logic [7:0] CH_FFEED = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;

    // result codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic KIND_SPEED    = 1'b0;
    localparam logic KIND_POSITION = 1'b1;

    localparam logic [1:0] ACT_ASSIGN   = 2'd0;
    localparam logic [1:0] ACT_INCREASE = 2'd1;
    localparam logic [1:0] ACT_DECREASE = 2'd2;

    typedef enum logic [1:0] {
        PH_WS,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } acfp_phase_t;

    // one classified byte
    typedef struct packed {
        logic       is_at;
        logic       is_bang;
        logic       is_hash;
        logic       is_eq;
        logic       is_ws;
        logic       is_plus;
        logic       is_minus;
        logic       is_dot;
        logic       is_digit;
        logic [3:0] digit;
        logic       kind_ok;
        logic       kind;
        logic       act_ok;
        logic [1:0] act;
    } acfp_token_t;

    // one completed frame, number still in decimal fraction form
    typedef struct packed {
        logic            status;
        logic            kind;
        logic [1:0]      action;
        logic            neg;
        logic            any;
        logic [IP_W-1:0] ip;
        logic [FD_W-1:0] fn;
        logic [FD_W-1:0] fd;
    } acfp_frame_t;

endpackage

/* hw/rtl/acfp_front.sv */
// ----------------------------------------------------------------------------
// acfp_front
// Input side: takes bytes, drops line breaks and classifies the rest.
// ----------------------------------------------------------------------------
module acfp_front
    import acfp_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    input  logic        q_full,
    output logic        push,
    output acfp_token_t push_tok
);

    logic is_break;

    assign s_ready  = !q_full;
    assign is_break = (s_byte_in == CH_CR) || (s_byte_in == CH_LF);
    assign push     = s_valid && !q_full && !is_break;

    always_comb begin
        push_tok          = '0;
        push_tok.is_at    = (s_byte_in == CH_AT);
        push_tok.is_bang  = (s_byte_in == CH_BANG);
        push_tok.is_hash  = (s_byte_in == CH_HASH);
        push_tok.is_eq    = (s_byte_in == CH_EQ);
        push_tok.is_ws    = (s_byte_in == CH_SPACE) || (s_byte_in == CH_TAB) ||
                            (s_byte_in == CH_VTAB) || (s_byte_in == CH_FFEED);
        push_tok.is_plus  = (s_byte_in == CH_PLUS);
        push_tok.is_minus = (s_byte_in == CH_MINUS);
        push_tok.is_dot   = (s_byte_in == CH_DOT);
        push_tok.is_digit = (s_byte_in >= CH_ZERO) && (s_byte_in <= CH_NINE);
        push_tok.digit    = s_byte_in[3:0];
        push_tok.kind_ok  = (s_byte_in == CH_S) || (s_byte_in == CH_P);
        push_tok.kind     = (s_byte_in == CH_P) ? KIND_POSITION : KIND_SPEED;
        push_tok.act_ok   = (s_byte_in == CH_ONE) || (s_byte_in == CH_TWO) ||
                            (s_byte_in == CH_THREE);
        priority if (s_byte_in == CH_TWO) begin
            push_tok.act = ACT_INCREASE;
        end else if (s_byte_in == CH_THREE) begin
            push_tok.act = ACT_DECREASE;
        end else begin
            push_tok.act = ACT_ASSIGN;
        end
    end

endmodule

/* hw/rtl/acfp_queue.sv */
// ----------------------------------------------------------------------------
// acfp_queue
// Short word queue between the classifier and the frame tracker.
// ----------------------------------------------------------------------------
module acfp_queue
    import acfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  acfp_token_t push_tok,
    output logic        full,
    input  logic        pop,
    output acfp_token_t head_tok,
    output logic        not_empty
);

    acfp_token_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_tok  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

/* hw/rtl/acfp_back.sv */
// ----------------------------------------------------------------------------
// acfp_back
// Frame tracker: sync, byte position, header checks and number accumulation.
// ----------------------------------------------------------------------------
module acfp_back
    import acfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        tok_valid,
    input  acfp_token_t tok,
    input  logic        adv,
    output logic        tok_pop,
    output logic        frm_valid,
    output acfp_frame_t frm
);

    logic              synced_reg, synced_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_bang_reg, last_bang_next;
    logic              bang_prior_reg, bang_prior_next;
    logic              kind_ok_reg, kind_ok_next;
    logic              kind_reg, kind_next;
    logic              act_ok_reg, act_ok_next;
    logic [1:0]        act_reg, act_next;
    logic              eq_ok_reg, eq_ok_next;
    acfp_phase_t       phase_reg, phase_next, phase_parse;
    logic              neg_reg, neg_next;
    logic              any_reg, any_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic [FD_W-1:0]   fn_reg, fn_next;
    logic [FD_W-1:0]   fd_reg, fd_next;

    logic              at_limit;
    logic              in_num;
    logic              len_ok;
    logic              num_ok;
    logic              int_digit;
    logic              frac_digit;
    logic              take_minus;
    logic [IP10_W-1:0] ip_x10;
    logic [IP_W-1:0]   ip_acc;
    logic [FD_W-1:0]   fn_acc;
    logic [FD_W-1:0]   fd_acc;

    assign tok_pop  = tok_valid && adv;
    assign at_limit = (cnt_reg == CNT_W'(STORE_DEPTH - 1));
    assign in_num   = (32'(cnt_reg) >= 32'(NUM_START));
    // frame length is the index of the closing hash plus one
    assign len_ok   = (32'(cnt_reg) < 32'(FRAME_MAX));
    assign num_ok   = (32'(cnt_reg) > 32'(NUM_START + 1)) &&
                      (32'(cnt_reg) < 32'(NUMBER_MAX + NUM_START + 1));

    // number scanner: next phase
    always_comb begin
        phase_parse = phase_reg;
        unique case (phase_reg)
            PH_WS: begin
                priority if (tok.is_ws) begin
                    phase_parse = PH_WS;
                end else if (tok.is_plus || tok.is_minus || tok.is_digit) begin
                    phase_parse = PH_INT;
                end else if (tok.is_dot) begin
                    phase_parse = PH_FRAC;
                end else begin
                    phase_parse = PH_STOP;
                end
            end
            PH_INT: begin
                priority if (tok.is_digit) begin
                    phase_parse = PH_INT;
                end else if (tok.is_dot) begin
                    phase_parse = PH_FRAC;
                end else begin
                    phase_parse = PH_STOP;
                end
            end
            PH_FRAC: begin
                phase_parse = tok.is_digit ? PH_FRAC : PH_STOP;
            end
            PH_STOP: begin
                phase_parse = PH_STOP;
            end
            default: begin
                phase_parse = PH_STOP;
            end
        endcase
    end

    // number scanner: accumulate actions
    always_comb begin
        int_digit  = tok.is_digit && ((phase_reg == PH_WS) || (phase_reg == PH_INT));
        frac_digit = tok.is_digit && (phase_reg == PH_FRAC);
        take_minus = tok.is_minus && (phase_reg == PH_WS);
        ip_x10     = {1'b0, ip_reg, 3'b000} + {3'b000, ip_reg, 1'b0} + IP10_W'(tok.digit);
        ip_acc     = (ip_x10 > IP10_W'(IP_SAT)) ? IP_SAT : ip_x10[IP_W-1:0];
        fn_acc     = FD_W'({fn_reg, 3'b000}) + FD_W'({fn_reg, 1'b0}) + FD_W'(tok.digit);
        fd_acc     = FD_W'({fd_reg, 3'b000}) + FD_W'({fd_reg, 1'b0});
    end

    always_comb begin
        synced_next     = synced_reg;
        cnt_next        = cnt_reg;
        last_bang_next  = last_bang_reg;
        bang_prior_next = bang_prior_reg;
        kind_ok_next    = kind_ok_reg;
        kind_next       = kind_reg;
        act_ok_next     = act_ok_reg;
        act_next        = act_reg;
        eq_ok_next      = eq_ok_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        any_next        = any_reg;
        ip_next         = ip_reg;
        fn_next         = fn_reg;
        fd_next         = fd_reg;
        if (tok_pop) begin
            if (!synced_reg) begin
                if (tok.is_at) begin
                    synced_next     = 1'b1;
                    cnt_next        = CNT_W'(1);
                    last_bang_next  = 1'b0;
                    bang_prior_next = 1'b0;
                    kind_ok_next    = 1'b0;
                    act_ok_next     = 1'b0;
                    eq_ok_next      = 1'b0;
                    phase_next      = PH_WS;
                    neg_next        = 1'b0;
                    any_next        = 1'b0;
                    ip_next         = '0;
                    fn_next         = '0;
                    fd_next         = FD_W'(1);
                end
            end else if (at_limit) begin
                // store overflow, back to hunting
                synced_next = 1'b0;
                cnt_next    = '0;
            end else begin
                cnt_next        = cnt_reg + CNT_W'(1);
                last_bang_next  = tok.is_bang;
                bang_prior_next = bang_prior_reg | last_bang_reg;
                if (cnt_reg == CNT_W'(IDX_KIND)) begin
                    kind_ok_next = tok.kind_ok;
                    kind_next    = tok.kind;
                end
                if (cnt_reg == CNT_W'(IDX_ACTION)) begin
                    act_ok_next = tok.act_ok;
                    act_next    = tok.act;
                end
                if (cnt_reg == CNT_W'(IDX_EQ)) begin
                    eq_ok_next = tok.is_eq;
                end
                if (in_num) begin
                    phase_next = phase_parse;
                    if (take_minus) begin
                        neg_next = 1'b1;
                    end
                    if (int_digit) begin
                        ip_next  = ip_acc;
                        any_next = 1'b1;
                    end
                    if (frac_digit) begin
                        fn_next  = fn_acc;
                        fd_next  = fd_acc;
                        any_next = 1'b1;
                    end
                end
                if (last_bang_reg && tok.is_hash) begin
                    synced_next = 1'b0;
                    cnt_next    = '0;
                end
            end
        end
    end

    // closing bang-hash; apart from the pop handshake, everything checked comes from registered state
    assign frm_valid = tok_pop && synced_reg && !at_limit && last_bang_reg &&
                       tok.is_hash && len_ok;

    always_comb begin
        frm        = '0;
        frm.status = (kind_ok_reg && act_ok_reg && eq_ok_reg && !bang_prior_reg && num_ok)
                     ? STATUS_OK : STATUS_BAD;
        frm.kind   = kind_reg;
        frm.action = act_reg;
        frm.neg    = neg_reg;
        frm.any    = any_reg;
        frm.ip     = ip_reg;
        frm.fn     = fn_reg;
        frm.fd     = fd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            synced_reg     <= 1'b0;
            cnt_reg        <= '0;
            last_bang_reg  <= 1'b0;
            bang_prior_reg <= 1'b0;
            kind_ok_reg    <= 1'b0;
            kind_reg       <= KIND_SPEED;
            act_ok_reg     <= 1'b0;
            act_reg        <= ACT_ASSIGN;
            eq_ok_reg      <= 1'b0;
            phase_reg      <= PH_WS;
            neg_reg        <= 1'b0;
            any_reg        <= 1'b0;
            ip_reg         <= '0;
            fn_reg         <= '0;
            fd_reg         <= FD_W'(1);
        end else begin
            synced_reg     <= synced_next;
            cnt_reg        <= cnt_next;
            last_bang_reg  <= last_bang_next;
            bang_prior_reg <= bang_prior_next;
            kind_ok_reg    <= kind_ok_next;
            kind_reg       <= kind_next;
            act_ok_reg     <= act_ok_next;
            act_reg        <= act_next;
            eq_ok_reg      <= eq_ok_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            any_reg        <= any_next;
            ip_reg         <= ip_next;
            fn_reg         <= fn_next;
            fd_reg         <= fd_next;
        end
    end

endmodule

/* hw/rtl/acfp_convert.sv */
// ----------------------------------------------------------------------------
// acfp_convert
// Pipelined fraction divider, one quotient bit per stage, then Q16.16
// assembly, saturation and the result register.
// ----------------------------------------------------------------------------
module acfp_convert
    import acfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frm_valid,
    input  acfp_frame_t        frm,
    output logic               adv,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic               m_kind,
    output logic [1:0]         m_action,
    output logic signed [31:0] m_value
);

    localparam int NSTG = FRAC_BITS;

    logic [NSTG-1:0]      vld_reg;
    acfp_frame_t          frm_reg  [NSTG];
    logic [FRAC_BITS-1:0] q_reg    [NSTG];

    acfp_frame_t          stg_in   [NSTG];
    logic [FRAC_BITS-1:0] q_in     [NSTG];
    logic [NSTG-1:0]      vld_in;
    acfp_frame_t          stg_next [NSTG];
    logic [FRAC_BITS-1:0] q_next   [NSTG];
    logic [FD_W:0]        dbl      [NSTG];
    logic [NSTG-1:0]      ge;

    acfp_frame_t          last;
    logic [MAG_W-1:0]     mag;
    logic [31:0]          value_calc;

    logic                 m_valid_reg;
    logic                 status_reg;
    logic                 kind_reg;
    logic [1:0]           action_reg;
    logic signed [31:0]   value_reg;

    assign adv = !m_valid_reg || m_ready;

    always_comb begin
        stg_in[0] = frm;
        q_in[0]   = '0;
        vld_in[0] = frm_valid;
        for (int i = 1; i < NSTG; i++) begin
            stg_in[i] = frm_reg[i-1];
            q_in[i]   = q_reg[i-1];
            vld_in[i] = vld_reg[i-1];
        end
        // restoring step: the remainder rides in the fn field
        for (int i = 0; i < NSTG; i++) begin
            dbl[i]      = {stg_in[i].fn, 1'b0};
            ge[i]       = (dbl[i] >= {1'b0, stg_in[i].fd});
            stg_next[i] = stg_in[i];
            stg_next[i].fn = ge[i] ? FD_W'(dbl[i] - {1'b0, stg_in[i].fd}) : FD_W'(dbl[i]);
            q_next[i]   = {q_in[i][FRAC_BITS-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NSTG; i++) begin
                frm_reg[i] <= stg_next[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    always_comb begin
        last = frm_reg[NSTG-1];
        mag  = {last.ip, q_reg[NSTG-1]};
        if (!last.any) begin
            value_calc = '0;
        end else if (last.neg) begin
            value_calc = (mag >= MAG_W'(33'h080000000)) ? 32'h80000000
                                                        : 32'(MAG_W'(0) - mag);
        end else begin
            value_calc = (mag > MAG_W'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : mag[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (last.status == STATUS_BAD) begin
                status_reg <= STATUS_BAD;
                kind_reg   <= KIND_SPEED;
                action_reg <= ACT_ASSIGN;
                value_reg  <= '0;
            end else begin
                status_reg <= STATUS_OK;
                kind_reg   <= last.kind;
                action_reg <= last.action;
                value_reg  <= signed'(value_calc);
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = status_reg;
    assign m_kind   = kind_reg;
    assign m_action = action_reg;
    assign m_value  = value_reg;

endmodule

/* hw/rtl/ascii_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// ascii_command_frame_parser
// Frames '@' kind action '=' number '!' '#' commands out of a byte stream
// and gives status, kind, action and the number as signed Q16.16.
//
//   channel  ports                                dir  word
//   input    s_valid s_ready s_byte_in            in   one received byte
//   result   m_valid m_ready m_status m_kind      out  one per completed frame
//            m_action m_value
//
// Takes one byte per cycle while s_ready is high. A frame closed by '#' passes
// the byte queue, then 16 fraction divider stages, one quotient bit each, the
// last feeding the result register that drives m_valid.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled result holds the divider pipeline; s_ready drops only when the
// four-word byte queue fills up.
// ----------------------------------------------------------------------------
module ascii_command_frame_parser
    import acfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic               m_kind,
    output logic [1:0]         m_action,
    output logic signed [31:0] m_value
);

    logic        q_full;
    logic        push;
    acfp_token_t push_tok;
    logic        tok_pop;
    acfp_token_t head_tok;
    logic        tok_valid;
    logic        adv;
    logic        frm_valid;
    acfp_frame_t frm;

    acfp_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .q_full    (q_full),
        .push      (push),
        .push_tok  (push_tok)
    );

    acfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_tok  (push_tok),
        .full      (q_full),
        .pop       (tok_pop),
        .head_tok  (head_tok),
        .not_empty (tok_valid)
    );

    acfp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (tok_valid),
        .tok       (head_tok),
        .adv       (adv),
        .tok_pop   (tok_pop),
        .frm_valid (frm_valid),
        .frm       (frm)
    );

    acfp_convert u_convert (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frm_valid (frm_valid),
        .frm       (frm),
        .adv       (adv),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_kind    (m_kind),
        .m_action  (m_action),
        .m_value   (m_value)
    );

endmodule

/* dv/tb_ascii_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// tb_ascii_command_frame_parser
// Self-checking testbench for the ascii command frame parser. Bytes are sent
// over the valid/ready input channel with random gaps, and results are taken
// with random stalls. A scoreboard tracks framing and decodes each completed
// command itself, then compares every result field by field, in order.
// ----------------------------------------------------------------------------
module tb_ascii_command_frame_parser
    import acfp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_WORDS = 850;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 38;

    typedef struct packed {
        logic        status;
        logic        kind;
        logic [1:0]  action;
        logic [31:0] value;
    } cmd_result_t;

    class frame_scoreboard;
        logic [7:0]  store [STORE_DEPTH];
        bit          synced;
        int          count;
        cmd_result_t pending [$];
        int          errors;

        function new();
            synced = 1'b0;
            count  = 0;
            errors = 0;
        endfunction

        function logic [7:0] stored_byte(int i, int len);
            if (i < len && i < STORE_DEPTH) begin
                return store[i];
            end
            return 8'd0;
        endfunction

        function bit is_digit_char(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // decimal prefix to signed Q16.16, truncated toward zero and saturated
        function logic [31:0] number_to_q16(int start, int n, int len);
            int              i;
            int              fk;
            logic [7:0]      c;
            logic [15:0]     fb;
            bit              neg;
            bit              any;
            longint unsigned ip;
            longint unsigned fn;
            longint unsigned fd;
            longint unsigned mag;
            i   = 0;
            fk  = 0;
            fb  = '0;
            neg = 1'b0;
            any = 1'b0;
            ip  = 0;
            fn  = 0;
            fd  = 1;
            while (i < n) begin
                c = stored_byte(start + i, len);
                if (c != CH_SPACE && c != CH_TAB && c != CH_VTAB && c != CH_FFEED &&
                    c != CH_CR && c != CH_LF) begin
                    break;
                end
                i++;
            end
            c = stored_byte(start + i, len);
            if (i < n && (c == CH_PLUS || c == CH_MINUS)) begin
                neg = (c == CH_MINUS);
                i++;
            end
            while (i < n && is_digit_char(stored_byte(start + i, len))) begin
                ip = ip * 10 + (64'(stored_byte(start + i, len)) - 64'(CH_ZERO));
                if (ip > 65536) begin
                    ip = 65536;
                end
                any = 1'b1;
                i++;
            end
            if (i < n && stored_byte(start + i, len) == CH_DOT) begin
                i++;
                while (i < n && is_digit_char(stored_byte(start + i, len))) begin
                    if (fk < 18) begin
                        fn = fn * 10 + (64'(stored_byte(start + i, len)) - 64'(CH_ZERO));
                        fd = fd * 10;
                        fk++;
                    end
                    any = 1'b1;
                    i++;
                end
            end
            if (!any) begin
                return 32'd0;
            end
            // one fraction bit per step by long division
            for (int k = 0; k < 16; k++) begin
                fn = fn * 2;
                fb = fb << 1;
                if (fn >= fd) begin
                    fb[0] = 1'b1;
                    fn    = fn - fd;
                end
            end
            mag = ip * 65536 + 64'(fb);
            if (neg) begin
                if (mag >= 64'h8000_0000) begin
                    return 32'h8000_0000;
                end
                return 32'(64'd0 - mag);
            end
            if (mag > 64'h7FFF_FFFF) begin
                return 32'h7FFF_FFFF;
            end
            return 32'(mag);
        endfunction

        function cmd_result_t decode_command(int len);
            cmd_result_t res;
            int          pos;
            logic [7:0]  c;
            logic        kd;
            logic [1:0]  ac;
            res        = '0;
            res.status = STATUS_BAD;
            if (stored_byte(0, len) != CH_AT || stored_byte(IDX_EQ, len) != CH_EQ) begin
                return res;
            end
            pos = 0;
            while (pos < FRAME_MAX && stored_byte(pos, len) != CH_BANG) begin
                pos++;
            end
            if (pos >= FRAME_MAX || stored_byte(pos + 1, len) != CH_HASH) begin
                return res;
            end
            c = stored_byte(IDX_KIND, len);
            if (c == CH_S) begin
                kd = KIND_SPEED;
            end else if (c == CH_P) begin
                kd = KIND_POSITION;
            end else begin
                return res;
            end
            c = stored_byte(IDX_ACTION, len);
            if (c == CH_ONE) begin
                ac = ACT_ASSIGN;
            end else if (c == CH_TWO) begin
                ac = ACT_INCREASE;
            end else if (c == CH_THREE) begin
                ac = ACT_DECREASE;
            end else begin
                return res;
            end
            if (pos <= NUM_START || pos - NUM_START >= NUMBER_MAX) begin
                return res;
            end
            res.status = STATUS_OK;
            res.kind   = kd;
            res.action = ac;
            res.value  = number_to_q16(NUM_START, pos - NUM_START, len);
            return res;
        endfunction

        // framing of one accepted input word
        function void note_byte(logic [7:0] b);
            int len;
            if (b == CH_LF || b == CH_CR) begin
                return;
            end
            if (!synced) begin
                if (b == CH_AT) begin
                    store[0] = b;
                    count    = 1;
                    synced   = 1'b1;
                end
                return;
            end
            if (count < STORE_DEPTH - 1) begin
                store[count] = b;
                count++;
            end else begin
                synced = 1'b0;
                count  = 0;
                return;
            end
            if (count < 2 || store[count - 2] != CH_BANG || store[count - 1] != CH_HASH) begin
                return;
            end
            len    = count;
            synced = 1'b0;
            count  = 0;
            if (len > FRAME_MAX) begin
                return;
            end
            pending.push_back(decode_command(len));
        endfunction

        function void check_result(logic st, logic kd, logic [1:0] ac, logic [31:0] va);
            cmd_result_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: status=%0d kind=%0d action=%0d value=%h",
                             st, kd, ac, va);
                end
                return;
            end
            want = pending.pop_front();
            if (want.status !== st || want.kind !== kd || want.action !== ac ||
                want.value !== va) begin
                errors++;
                if (errors <= 10) begin
                    $display({"mismatch: expected status=%0d kind=%0d action=%0d value=%h,",
                              " got status=%0d kind=%0d action=%0d value=%h"},
                             want.status, want.kind, want.action, want.value,
                             st, kd, ac, va);
                end
            end
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_byte_in = 8'd0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic               m_status;
    logic               m_kind;
    logic [1:0]         m_action;
    logic signed [31:0] m_value;

    frame_scoreboard board;
    logic [7:0]      tx_q [$];
    int              item_count = 0;
    int              cycles     = 0;
    bit              calm       = 1'b0;
    bit              drained    = 1'b0;

    ascii_command_frame_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_kind    (m_kind),
        .m_action  (m_action),
        .m_value   (m_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // result side: check on accept, then pick ready for the next edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_result(m_status, m_kind, m_action, m_value);
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // queue a word, now and then with a stray line break in front
    function automatic void put(logic [7:0] b);
        if ($urandom_range(99) < 3) begin
            tx_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
        end
        tx_q.push_back(b);
        item_count++;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            put(s[i]);
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        board.note_byte(b);
    endtask

    task automatic flush_tx();
        while (tx_q.size() != 0) begin
            send_byte(tx_q.pop_front());
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic queue_random_frame();
        int         mode;
        logic [7:0] blanks [4];
        blanks = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED};
        mode   = $urandom_range(99);
        // line noise ahead of the frame is not counted as work
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 4)) tx_q.push_back(8'($urandom_range(255)));
        end
        put(CH_AT);
        if (mode < 8) begin
            // long digit run: long frame or store overflow
            repeat ($urandom_range(18, STORE_DEPTH + 2)) begin
                put(8'(CH_ZERO + $urandom_range(9)));
            end
        end else if (mode < 16) begin
            repeat ($urandom_range(1, 18)) put(8'($urandom_range(255)));
        end else begin
            put($urandom_range(99) < 5 ? 8'($urandom_range(255))
                                       : ($urandom_range(1) ? CH_P : CH_S));
            put($urandom_range(99) < 5 ? 8'($urandom_range(255))
                                       : 8'(CH_ONE + $urandom_range(2)));
            put($urandom_range(99) < 5 ? 8'($urandom_range(255)) : CH_EQ);
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 2)) put(blanks[$urandom_range(3)]);
            end
            if ($urandom_range(99) < 45) begin
                put($urandom_range(1) ? CH_MINUS : CH_PLUS);
            end
            repeat ($urandom_range(0, 6)) put(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(99) < 60) begin
                put(CH_DOT);
                repeat ($urandom_range(0, 8)) put(8'(CH_ZERO + $urandom_range(9)));
            end
            if ($urandom_range(99) < 10) begin
                put($urandom_range(1) ? 8'h65 : 8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 6) begin
                put(CH_BANG);
                put(8'($urandom_range(CH_SPACE, 8'h7E)));
            end
        end
        put(CH_BANG);
        put(CH_HASH);
    endtask

    initial begin
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_q.push_back(8'h00);
        tx_q.push_back(8'hFF);
        push_text("zz");
        put(CH_CR);
        put(CH_LF);
        push_text("@S1=1.5!#");
        push_text("@P2=-2.25!#");
        push_text("@S3= +.5!#");
        push_text("@P1=32767.99999!#");
        push_text("@P1=99999!#");
        push_text("@S1=-32768!#");
        push_text("@S2=-99999.9!#");
        push_text("@S2=-0.00001!#");
        push_text("@S2=1e5!#");
        push_text("@P3=inf!#");
        push_text("@S3=0x1F!#");
        push_text("@P1=");
        put(CH_TAB);
        put(CH_VTAB);
        put(CH_FFEED);
        push_text("-7!#");
        push_text("@S1=!#");
        push_text("@X1=1!#");
        push_text("@S4=1!#");
        push_text("@S1:1!#");
        push_text("@S1=1!x2!#");
        push_text("@!#");
        push_text("@S1=-!#");
        push_text("@P2=- 5!#");
        push_text("@P1=123456789012345!#");
        push_text("@P1=1234567890123456!#");
        // fill the store; the next '@' is lost and its frame with it
        put(CH_AT);
        repeat (STORE_DEPTH - 2) put(CH_NINE);
        push_text("@S1=3!#");
        push_text("@P3=0.999999999999!#");
        push_text("@S1=1.");
        put(CH_LF);
        put(CH_CR);
        push_text("5!#");
        flush_tx();
        wait_drain();

        item_count = 0;
        while (item_count < RANDOM_WORDS) begin
            calm = (item_count >= 400 && item_count < 600);
            if (!drained && item_count >= 800) begin
                wait_drain();
                drained = 1'b1;
            end
            queue_random_frame();
            flush_tx();
        end
        calm = 1'b0;

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
